/* hw/rtl/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the bitmap slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int WORD_W      = 32;
  localparam int WBITS       = $clog2(WORD_W);
  localparam int WORDS       = MAX_ENTRIES / WORD_W;
  localparam int WAW         = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = 10;
  localparam int CFG_W       = 11;
  localparam int FREE_W      = 11;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FREE  = 2'd3;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  granted_index;
    logic [1:0]        status;
    logic [FREE_W-1:0] free_count;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/bitmap_slot_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Used-slot bitmap allocator: allocate lowest clear entry, or free one entry.
// ----------------------------------------------------------------------------
// Allocate: result registered after a scan of one 32-entry word per cycle, from
//   word 0 up to the first with a free entry or the last configured word.
// Free: the word is read, then checked and written back as the result is registered.
// Next transfer only in idle, once the result is registered; an output register
//   that is held stalls the result and so the next transfer.
// Reset: entry 0 used, others free, count 1024; per-word valid flags mask RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              req_valid,
  output logic                             req_ready,
  input  bsa_pkg::req_t                    req_data,
  output logic                             rsp_valid,
  input  wire                              rsp_ready,
  output bsa_pkg::rsp_t                    rsp_data,
  input  wire                              cfg_we,
  input  wire  [bsa_pkg::CFG_W-1:0]        cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FREE} state_t;

  state_t                           state;
  logic [bsa_pkg::WAW-1:0]          scan_word;
  logic [bsa_pkg::IDX_W-1:0]        free_idx;
  logic                             range_bad;
  logic [bsa_pkg::CNT_W-1:0]        used_total;
  logic [bsa_pkg::CFG_W-1:0]        entry_count;
  logic [bsa_pkg::WORDS-1:0]        word_vld;

  logic [bsa_pkg::WORD_W-1:0]       mem [bsa_pkg::WORDS];
  logic [bsa_pkg::WORD_W-1:0]       rd_q;
  logic                             rd_vld_q;
  logic [bsa_pkg::WAW-1:0]          rd_word_q;
  logic [bsa_pkg::WAW-1:0]          rd_addr;
  logic                             mem_we;
  logic [bsa_pkg::WAW-1:0]          mem_waddr;
  logic [bsa_pkg::WORD_W-1:0]       mem_wdata;

  logic [31:0]                      n32;
  logic [bsa_pkg::CNT_W-1:0]        n_eff;
  logic [bsa_pkg::CNT_W-1:0]        n_hi;
  logic [bsa_pkg::CNT_W-1:0]        nwords;
  logic [bsa_pkg::WORD_W-1:0]       word_eff;
  logic [bsa_pkg::WORD_W-1:0]       lim;
  logic [bsa_pkg::WORD_W-1:0]       avail;
  logic                             hit;
  logic [bsa_pkg::WBITS-1:0]        hit_bit;
  logic                             last;
  logic [bsa_pkg::WAW-1:0]          req_word;
  logic [bsa_pkg::WAW-1:0]          free_word;
  logic                             free_bit;
  logic                             can_emit;
  logic                             req_xfer;
  logic [bsa_pkg::CNT_W-1:0]        used_total_next;
  logic [bsa_pkg::FREE_W-1:0]       free_next;
  logic [1:0]                       status_next;
  logic [bsa_pkg::IDX_W-1:0]        grant_next;
  logic                             emit;

  assign n32   = (32'(entry_count) > 32'(bsa_pkg::MAX_ENTRIES)) ?
                 32'(bsa_pkg::MAX_ENTRIES) : 32'(entry_count);
  assign n_eff  = bsa_pkg::CNT_W'(n32);
  assign n_hi   = n_eff >> bsa_pkg::WBITS;
  assign nwords = bsa_pkg::CNT_W'((n32 + 32'(bsa_pkg::WORD_W - 1)) >> bsa_pkg::WBITS);

  assign word_eff = rd_vld_q ? rd_q :
                    ((rd_word_q == '0) ? bsa_pkg::WORD_W'(1) : '0);

  always_comb begin
    if (bsa_pkg::CNT_W'(scan_word) < n_hi) begin
      lim = '1;
    end else if (bsa_pkg::CNT_W'(scan_word) == n_hi) begin
      lim = (bsa_pkg::WORD_W'(1) << n_eff[bsa_pkg::WBITS-1:0]) - bsa_pkg::WORD_W'(1);
    end else begin
      lim = '0;
    end
  end

  assign avail = ~word_eff & lim;

  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = bsa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        hit     = 1'b1;
        hit_bit = bsa_pkg::WBITS'(b);
      end
    end
  end

  assign last      = (bsa_pkg::CNT_W'(scan_word) + bsa_pkg::CNT_W'(1)) >= nwords;
  assign req_word  = bsa_pkg::WAW'(req_data.slot_index >> bsa_pkg::WBITS);
  assign free_word = bsa_pkg::WAW'(free_idx >> bsa_pkg::WBITS);
  assign free_bit  = word_eff[free_idx[bsa_pkg::WBITS-1:0]];
  assign can_emit  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);
  assign req_xfer  = req_valid && req_ready;

  always_comb begin
    rd_addr         = scan_word;
    mem_we          = 1'b0;
    mem_waddr       = scan_word;
    mem_wdata       = word_eff;
    used_total_next = used_total;
    status_next     = bsa_pkg::ST_OK;
    grant_next      = '0;
    emit            = 1'b0;
    case (state)
      S_IDLE: begin
        rd_addr = (req_data.action == bsa_pkg::ACT_FREE) ? req_word : '0;
      end
      S_SCAN: begin
        rd_addr = (hit || last) ? scan_word : scan_word + bsa_pkg::WAW'(1);
        if (hit || last) begin
          emit = can_emit;
          if (hit) begin
            mem_we          = can_emit;
            mem_wdata       = word_eff | (bsa_pkg::WORD_W'(1) << hit_bit);
            used_total_next = used_total + bsa_pkg::CNT_W'(1);
            grant_next      = bsa_pkg::IDX_W'({scan_word, hit_bit});
          end else begin
            status_next = bsa_pkg::ST_FULL;
          end
        end
      end
      S_FREE: begin
        rd_addr   = free_word;
        mem_waddr = free_word;
        emit      = can_emit;
        if (range_bad) begin
          status_next = bsa_pkg::ST_RANGE;
        end else if (!free_bit) begin
          status_next = bsa_pkg::ST_FREE;
        end else begin
          mem_we    = can_emit;
          mem_wdata = word_eff & ~(bsa_pkg::WORD_W'(1) << free_idx[bsa_pkg::WBITS-1:0]);
          used_total_next = (used_total != '0) ? used_total - bsa_pkg::CNT_W'(1) : '0;
        end
      end
      default: begin
        rd_addr = scan_word;
      end
    endcase
  end

  assign free_next = (n_eff > used_total_next) ?
                     bsa_pkg::FREE_W'(n_eff - used_total_next) : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q      <= mem[rd_addr];
    rd_vld_q  <= word_vld[rd_addr];
    rd_word_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      scan_word   <= '0;
      used_total  <= bsa_pkg::CNT_W'(1);
      entry_count <= bsa_pkg::CFG_W'(1024);
      word_vld    <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        entry_count <= cfg_data;
      end
      if (mem_we) begin
        word_vld[mem_waddr] <= 1'b1;
      end
      if (emit) begin
        rsp_valid              <= 1'b1;
        rsp_data.granted_index <= grant_next;
        rsp_data.status        <= status_next;
        rsp_data.free_count    <= free_next;
        used_total             <= used_total_next;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            scan_word <= '0;
            free_idx  <= req_data.slot_index;
            range_bad <= (req_data.slot_index == '0) ||
                         (bsa_pkg::CNT_W'(req_data.slot_index) >= n_eff);
            state     <= (req_data.action == bsa_pkg::ACT_FREE) ? S_FREE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (emit) begin
            state <= S_IDLE;
          end else if (!hit && !last) begin
            scan_word <= scan_word + bsa_pkg::WAW'(1);
          end
        end
        S_FREE: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(used_total) <= 32'(bsa_pkg::MAX_ENTRIES))
    else $error("used total above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> !req_ready)
    else $error("second transfer taken while busy");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != bsa_pkg::ST_OK) |-> (rsp_data.granted_index == '0))
    else $error("index granted on a failed request");

  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> emit)
    else $error("bitmap written without a result");

endmodule

`default_nettype wire
